// ===== sv/pemat_pkg.sv =====
// shared constants, codes and the case folding function for the path exclude matcher
package pemat_pkg;

  localparam int DEF_PATTERNS      = 16;
  localparam int DEF_PATTERN_CHARS = 64;

  localparam logic [15:0] DOT_UNIT = 16'h002E;

  // input item kinds
  localparam logic [1:0] KIND_PATTERN = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_PATH    = 2'd2;

  // result kinds
  localparam logic RES_ADD  = 1'b0;
  localparam logic RES_PATH = 1'b1;

  // add status codes
  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // ascii a-z folds to A-Z, all else unchanged
  function automatic logic [15:0] fold_unit(input logic [15:0] c);
    logic [15:0] r;
    r = c;
    if (c >= 16'h0061 && c <= 16'h007A) r = c - 16'h0020;
    return r;
  endfunction

endpackage

// ===== sv/path_exclude_pattern_matcher.sv =====
// path exclude pattern matcher: pattern table, shift-and matching, match counter
//
// One input channel: an item (kind, code_unit, last) is taken at a rising edge
// with start high and busy low. Results come out for exactly one cycle with
// done high; the receiver cannot stall them.
// Pattern units and clear items are handled in the accept cycle: busy stays
// low and an add status (on the final pattern unit) shows on the next cycle.
// A path unit walks every stored pattern unit through the single store read
// port and one shared compare, each stored unit in an address state and then
// a compare state, followed by a finishing state, busy high meanwhile. The
// verdict on the final path unit shows in the same cycle as busy falls.
// Reset clears the pattern count, the collection in progress, the partial
// match vectors, hit flags and the 64-bit match counter. The pattern store
// needs no clearing: only written units are ever read.
module path_exclude_pattern_matcher
  import pemat_pkg::*;
#(
  parameter int PATTERNS      = DEF_PATTERNS,
  parameter int PATTERN_CHARS = DEF_PATTERN_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [15:0] code_unit,
  input  logic        last,
  output logic        done,
  output logic        result_kind,
  output logic [1:0]  add_status,
  output logic        excluded,
  output logic [$clog2(PATTERNS+1)-1:0] pattern_total_out,
  output logic [63:0] match_total
);

  localparam int TW = $clog2(PATTERNS + 1);
  localparam int IW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int LW = $clog2(PATTERN_CHARS + 1);
  localparam int JW = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
  localparam int DEPTH = PATTERNS * PATTERN_CHARS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [15:0] store [DEPTH];
  logic [LW-1:0] plen [PATTERNS];
  logic [PATTERN_CHARS-1:0] pm [PATTERNS];
  logic [PATTERNS-1:0] hit;
  logic [TW-1:0] total;
  logic [LW-1:0] collect_len;
  logic collect_ovf;
  logic [63:0] counter;

  logic [15:0] fc;
  logic plast;
  logic [IW-1:0] pi;
  logic [JW-1:0] pj;
  logic [15:0] rdata;
  logic [PATTERN_CHARS-1:0] nxt;
  logic dot;
  logic excl;

  logic accept;
  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [PATTERN_CHARS-1:0] prev;
  logic [LW-1:0] cur_len;
  logic before_ok, bit_hit, at_end, pat_end;
  logic [PATTERN_CHARS-1:0] nxt_full;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // store write and registered read
  assign wr_en   = accept && kind == KIND_PATTERN && collect_len < LW'(PATTERN_CHARS)
                   && total < TW'(PATTERNS);
  assign wr_addr = AW'(total * PATTERN_CHARS + collect_len);
  assign rd_addr = AW'(pi * PATTERN_CHARS + pj);

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= code_unit;
    if (state == S_RD) rdata <= store[rd_addr];
  end

  // shared compare of one stored unit against the folded path unit
  always_comb begin
    prev      = pm[pi];
    cur_len   = plen[pi];
    before_ok = (pj == '0) || prev[pj - JW'(1)];
    bit_hit   = before_ok && (fold_unit(rdata) == fc);
    nxt_full  = nxt;
    nxt_full[pj] = bit_hit;
    at_end    = (LW'(pj) == cur_len - LW'(1));
    pat_end   = (TW'(pi) == total - TW'(1));
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      total       <= '0;
      collect_len <= '0;
      collect_ovf <= 1'b0;
      hit         <= '0;
      counter     <= '0;
      done        <= 1'b0;
      for (int k = 0; k < PATTERNS; k++) pm[k] <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (kind == KIND_PATTERN) begin
              if (last) begin
                done        <= 1'b1;
                result_kind <= RES_ADD;
                excluded    <= 1'b0;
                match_total <= counter;
                collect_len <= '0;
                collect_ovf <= 1'b0;
                priority if (collect_ovf || collect_len >= LW'(PATTERN_CHARS)) begin
                  add_status        <= ST_TOO_LONG;
                  pattern_total_out <= total;
                end else if (total >= TW'(PATTERNS)) begin
                  add_status        <= ST_FULL;
                  pattern_total_out <= total;
                end else begin
                  add_status                 <= ST_ADDED;
                  plen[IW'(total)]           <= collect_len + LW'(1);
                  pm[IW'(total)]             <= '0;
                  hit[IW'(total)]            <= 1'b0;
                  total                      <= total + TW'(1);
                  pattern_total_out          <= total + TW'(1);
                end
              end else if (collect_len < LW'(PATTERN_CHARS)) begin
                collect_len <= collect_len + LW'(1);
              end else begin
                collect_ovf <= 1'b1;
              end
            end else if (kind == KIND_CLEAR) begin
              total       <= '0;
              collect_len <= '0;
              collect_ovf <= 1'b0;
              hit         <= '0;
              for (int k = 0; k < PATTERNS; k++) pm[k] <= '0;
            end else if (kind == KIND_PATH) begin
              fc    <= fold_unit(code_unit);
              plast <= last;
              pi    <= '0;
              pj    <= '0;
              nxt   <= '0;
              excl  <= 1'b0;
              state <= (total == '0) ? S_FIN : S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (pj == '0) dot <= (rdata == DOT_UNIT);
          if (at_end) begin
            pm[pi] <= nxt_full;
            if (bit_hit) hit[pi] <= 1'b1;
            if (((pj == '0) ? (rdata == DOT_UNIT) : dot) ? bit_hit : (hit[pi] || bit_hit))
              excl <= 1'b1;
            nxt <= '0;
            pj  <= '0;
            if (pat_end) begin
              state <= S_FIN;
            end else begin
              pi    <= pi + IW'(1);
              state <= S_RD;
            end
          end else begin
            nxt   <= nxt_full;
            pj    <= pj + JW'(1);
            state <= S_RD;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          if (plast) begin
            done              <= 1'b1;
            result_kind       <= RES_PATH;
            add_status        <= ST_ADDED;
            excluded          <= excl;
            pattern_total_out <= total;
            match_total       <= excl ? counter + 64'd1 : counter;
            if (excl) counter <= counter + 64'd1;
            hit <= '0;
            for (int k = 0; k < PATTERNS; k++) pm[k] <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(PATTERNS)) else $error("pattern count past table size");
  a_path_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_PATH) |=> busy) else $error("path beat did not start a walk");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");
  a_verdict_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind == RES_PATH && excluded) |-> match_total == counter)
    else $error("counter and verdict disagree");

endmodule
